// ===== hdl/pttl_pkg.sv =====
package pttl_pkg;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_DELETE  = 3'd1,
      OP_LOOKUP  = 3'd2,
      OP_SET_TTL = 3'd3,
      OP_TICK    = 3'd4,
      OP_PURGE   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SORT,
      ST_CLOSE
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_ROTATE,
      CELL_TICK,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cell_ctrl_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  iface;
      logic [7:0]  func;
      logic [15:0] parent;
      logic [7:0]  pstat;
      logic [15:0] ttl;
   } entry_data_type;

   typedef struct packed {
      logic           valid;
      entry_data_type data;
   } entry_type;

   localparam logic [15:0] DEFAULT_TTL_RESET = 16'd10;

endpackage

// ===== hdl/pttl_req_if.sv =====
interface pttl_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [15:0] transaction_id;
   logic [7:0]  interface_id;
   logic [7:0]  function_id;
   logic [15:0] parent_txn_id;
   logic [7:0]  parent_state;
   logic [15:0] ttl_value;

   modport source (
      output valid, operation, transaction_id, interface_id, function_id,
             parent_txn_id, parent_state, ttl_value,
      input  ready
   );

   modport sink (
      input  valid, operation, transaction_id, interface_id, function_id,
             parent_txn_id, parent_state, ttl_value,
      output ready
   );
endinterface

// ===== hdl/pttl_rsp_if.sv =====
interface pttl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] entry_id;
   logic [7:0]  entry_interface;
   logic [7:0]  entry_function;
   logic [15:0] entry_parent;
   logic [7:0]  entry_parent_state;
   logic [15:0] entry_ttl;
   logic        last;

   modport source (
      output valid, status, entry_id, entry_interface, entry_function,
             entry_parent, entry_parent_state, entry_ttl, last,
      input  ready
   );

   modport sink (
      input  valid, status, entry_id, entry_interface, entry_function,
             entry_parent, entry_parent_state, entry_ttl, last,
      output ready
   );
endinterface

// ===== hdl/pttl_csr_if.sv =====
interface pttl_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] default_ttl;

   modport source (
      output valid, default_ttl,
      input  ready
   );

   modport sink (
      input  valid, default_ttl,
      output ready
   );
endinterface

// ===== hdl/pttl_cell.sv =====
module pttl_cell #(
   parameter bit FIRST = 1'b0,
   parameter bit LAST  = 1'b0,
   parameter bit ODD   = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pttl_pkg::cell_ctrl_type ctrl,
   input  pttl_pkg::entry_type     prev_entry,
   input  pttl_pkg::entry_type     next_entry,
   output pttl_pkg::entry_type     entry
);

   logic                     valid_ff;
   logic                     valid_in;
   pttl_pkg::entry_data_type data_ff;
   pttl_pkg::entry_data_type data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (ctrl.op)
         pttl_pkg::CELL_PUSH: begin
            valid_in = prev_entry.valid;
            data_in  = prev_entry.data;
         end
         pttl_pkg::CELL_ROTATE: begin
            valid_in = next_entry.valid;
            data_in  = next_entry.data;
         end
         pttl_pkg::CELL_TICK: begin
            if (valid_ff && (data_ff.ttl != 16'd0)) begin
               data_in.ttl = data_ff.ttl - 16'd1;
            end
         end
         pttl_pkg::CELL_SORT: begin
            // move an empty cell one step toward the tail
            if (ODD == ctrl.phase) begin
               if (!LAST && !valid_ff && next_entry.valid) begin
                  valid_in = next_entry.valid;
                  data_in  = next_entry.data;
               end
            end else begin
               if (!FIRST && !prev_entry.valid && valid_ff) begin
                  valid_in = prev_entry.valid;
                  data_in  = prev_entry.data;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry = '{valid: valid_ff, data: data_ff};

endmodule

// ===== hdl/pttl_ctrl.sv =====
module pttl_ctrl #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   pttl_req_if.sink                req,
   pttl_rsp_if.source              rsp,
   pttl_csr_if.sink                csr,
   input  pttl_pkg::entry_type     head,
   input  logic                    full,
   output pttl_pkg::cell_ctrl_type cell_ctrl,
   output pttl_pkg::entry_type     new_entry,
   output pttl_pkg::entry_type     wrap_entry
);

   localparam int STEP_W = $clog2(TABLE_DEPTH);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_DEPTH - 1);

   pttl_pkg::state_type      state_ff;
   pttl_pkg::state_type      state_in;
   pttl_pkg::op_type         op_ff;
   pttl_pkg::entry_data_type req_data_ff;
   logic                     found_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     phase_ff;
   logic [15:0]              default_ttl_ff;
   logic                     rsp_valid_ff;
   pttl_pkg::status_type     rsp_status_ff;
   pttl_pkg::entry_data_type rsp_data_ff;
   logic                     rsp_last_ff;

   logic                     accept;
   logic                     can_emit;
   logic                     hit;
   logic                     advance;
   logic                     emit;
   pttl_pkg::status_type     emit_status;
   pttl_pkg::entry_data_type emit_data;
   logic                     emit_last;
   logic                     step_done;

   assign req.ready = (state_ff == pttl_pkg::ST_IDLE);
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign can_emit  = !rsp_valid_ff || rsp.ready;
   assign step_done = (step_ff == LAST_STEP);

   always_comb begin
      new_entry          = '{valid: 1'b1, data: req_data_ff};
      new_entry.data.ttl = default_ttl_ff;
   end

   always_comb begin
      if (op_ff == pttl_pkg::OP_PURGE) begin
         hit = head.valid && (head.data.ttl == 16'd0);
      end else begin
         hit = head.valid && (head.data.id == req_data_ff.id) && !found_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pttl_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (pttl_pkg::op_type'(req.operation)) inside
                  pttl_pkg::OP_DELETE, pttl_pkg::OP_LOOKUP,
                  pttl_pkg::OP_SET_TTL, pttl_pkg::OP_PURGE: begin
                     state_in = pttl_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = pttl_pkg::ST_EXEC;
                  end
               endcase
            end
         end
         pttl_pkg::ST_EXEC: begin
            if (can_emit) begin
               state_in = pttl_pkg::ST_IDLE;
            end
         end
         pttl_pkg::ST_SCAN: begin
            if (advance && step_done) begin
               if ((op_ff == pttl_pkg::OP_DELETE) || (op_ff == pttl_pkg::OP_PURGE)) begin
                  state_in = pttl_pkg::ST_SORT;
               end else if (found_ff || hit) begin
                  state_in = pttl_pkg::ST_IDLE;
               end else begin
                  state_in = pttl_pkg::ST_CLOSE;
               end
            end
         end
         pttl_pkg::ST_SORT: begin
            if (step_done) begin
               if ((op_ff == pttl_pkg::OP_PURGE) || !found_ff) begin
                  state_in = pttl_pkg::ST_CLOSE;
               end else begin
                  state_in = pttl_pkg::ST_IDLE;
               end
            end
         end
         pttl_pkg::ST_CLOSE: begin
            if (can_emit) begin
               state_in = pttl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pttl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cell_ctrl   = '{op: pttl_pkg::CELL_HOLD, phase: phase_ff};
      wrap_entry  = head;
      advance     = 1'b0;
      emit        = 1'b0;
      emit_status = pttl_pkg::STATUS_OK;
      emit_data   = '0;
      emit_last   = 1'b1;
      unique case (state_ff)
         pttl_pkg::ST_IDLE: begin
         end
         pttl_pkg::ST_EXEC: begin
            if (can_emit) begin
               emit = 1'b1;
               case (op_ff)
                  pttl_pkg::OP_ADD: begin
                     if (full) begin
                        emit_status = pttl_pkg::STATUS_FULL;
                     end else begin
                        cell_ctrl.op = pttl_pkg::CELL_PUSH;
                        emit_data    = new_entry.data;
                     end
                  end
                  pttl_pkg::OP_TICK: begin
                     cell_ctrl.op = pttl_pkg::CELL_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pttl_pkg::ST_SCAN: begin
            advance = !hit || can_emit;
            if (advance) begin
               cell_ctrl.op = pttl_pkg::CELL_ROTATE;
            end
            if (hit) begin
               case (op_ff) inside
                  pttl_pkg::OP_DELETE, pttl_pkg::OP_PURGE: begin
                     wrap_entry.valid = 1'b0;
                  end
                  pttl_pkg::OP_SET_TTL: begin
                     wrap_entry.data.ttl = req_data_ff.ttl;
                  end
                  default: begin
                  end
               endcase
               emit      = can_emit;
               emit_data = wrap_entry.data;
               emit_last = (op_ff != pttl_pkg::OP_PURGE);
            end
         end
         pttl_pkg::ST_SORT: begin
            cell_ctrl.op = pttl_pkg::CELL_SORT;
         end
         pttl_pkg::ST_CLOSE: begin
            if (can_emit) begin
               emit = 1'b1;
               if (op_ff != pttl_pkg::OP_PURGE) begin
                  emit_status = pttl_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pttl_pkg::ST_IDLE;
         found_ff       <= 1'b0;
         step_ff        <= '0;
         phase_ff       <= 1'b0;
         default_ttl_ff <= pttl_pkg::DEFAULT_TTL_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            found_ff <= 1'b0;
         end else if ((state_ff == pttl_pkg::ST_SCAN) && hit && can_emit &&
                      (op_ff != pttl_pkg::OP_PURGE)) begin
            found_ff <= 1'b1;
         end
         if (accept) begin
            step_ff <= '0;
         end else if (((state_ff == pttl_pkg::ST_SCAN) && advance) ||
                      (state_ff == pttl_pkg::ST_SORT)) begin
            step_ff <= step_done ? '0 : step_ff + STEP_W'(1);
         end
         if (accept) begin
            phase_ff <= 1'b0;
         end else if (state_ff == pttl_pkg::ST_SORT) begin
            phase_ff <= !phase_ff;
         end
         if (csr.valid && csr.ready) begin
            default_ttl_ff <= csr.default_ttl;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff              <= pttl_pkg::op_type'(req.operation);
         req_data_ff.id     <= req.transaction_id;
         req_data_ff.iface  <= req.interface_id;
         req_data_ff.func   <= req.function_id;
         req_data_ff.parent <= req.parent_txn_id;
         req_data_ff.pstat  <= req.parent_state;
         req_data_ff.ttl    <= req.ttl_value;
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_data_ff   <= emit_data;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.status             = rsp_status_ff;
   assign rsp.entry_id           = rsp_data_ff.id;
   assign rsp.entry_interface    = rsp_data_ff.iface;
   assign rsp.entry_function     = rsp_data_ff.func;
   assign rsp.entry_parent       = rsp_data_ff.parent;
   assign rsp.entry_parent_state = rsp_data_ff.pstat;
   assign rsp.entry_ttl          = rsp_data_ff.ttl;
   assign rsp.last               = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != pttl_pkg::ST_IDLE))
      else $error("beat accepted but control stayed idle");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pttl_pkg::ST_SCAN) && hit && !can_emit)
         |=> ($stable(step_ff) && (state_ff == pttl_pkg::ST_SCAN)))
      else $error("scan advanced past a hit whose beat could not be sent");

   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (op_ff != pttl_pkg::OP_PURGE))
      else $error("match flag set during purge");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pttl_pkg::ST_CLOSE) && can_emit) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("closing beat missing or not marked last");

endmodule

// ===== hdl/pending_transaction_table_ttl.sv =====
// Table of open transactions kept as a chain of TABLE_DEPTH cells ordered by age, newest in
// the head cell. Add and tick are accepted, then act and register the result in the exec
// state. Lookup and set ttl rotate the whole chain once past the head comparator, then send
// a not-found beat when the id is not found. Delete and purge also run an odd-even
// compaction pass after the rotation, then send a closing beat (purge) or a not-found beat
// (delete with no match). The rotation stalls while the result beat of a hit cannot leave.
// A new request is taken once the previous one is complete, even while its last result
// beat still waits in the output register. The default ttl register resets to 10 and is
// written through the csr channel.
module pending_transaction_table_ttl #(
   parameter int TABLE_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   pttl_req_if.sink   req,
   pttl_rsp_if.source rsp,
   pttl_csr_if.sink   csr
);

   pttl_pkg::entry_type     entries [TABLE_DEPTH];
   pttl_pkg::cell_ctrl_type cell_ctrl;
   pttl_pkg::entry_type     new_entry;
   pttl_pkg::entry_type     wrap_entry;

   pttl_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .head       (entries[0]),
      .full       (entries[TABLE_DEPTH-1].valid),
      .cell_ctrl  (cell_ctrl),
      .new_entry  (new_entry),
      .wrap_entry (wrap_entry)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      pttl_pkg::entry_type prev_entry;
      pttl_pkg::entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = new_entry;
      end else begin : g_inner_prev
         assign prev_entry = entries[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_entry = wrap_entry;
      end else begin : g_inner_next
         assign next_entry = entries[i+1];
      end

      pttl_cell #(
         .FIRST (i == 0),
         .LAST  (i == TABLE_DEPTH - 1),
         .ODD   (1'(i % 2))
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entries[i])
      );
   end

endmodule
